@@ sv/pfcmt_pkg.sv @@
`default_nettype none

package pfcmt_pkg;

    // result field widths
    localparam int TOTAL_W    = 5;
    localparam int DISTINCT_W = 4;
    localparam int BEST_W     = 31;

    // trial division starts here
    localparam int FIRST_DIVISOR = 2;

endpackage

`default_nettype wire

@@ sv/prime_factor_count_max_tracker.sv @@
`default_nettype none

// prime factor counter with per-set best tracking
//
// input channel  : value, last with in_valid / in_stall; one transfer per item
// output channel : one result per item with out_valid / out_stall
// each value is factored by trial division from 2 while divisor squared is
// no greater than the cofactor; every trial is one radix-2 restoring division
// that retires one quotient bit per cycle, followed by a decision step, and
// each new divisor gets a square test first; a 31-bit prime needs roughly
// 46341 trials; values 0 and 1 skip trial division and go straight to finish
// the block works on one item at a time; in_stall is high from acceptance
// until the result has been moved into the output register
// the output register lets the next item be accepted while a result waits;
// a stalled result holds, and a finished item waits in its last step until
// the output register frees up
// reset clears the bests, empties the output register and returns to idle;
// the bests are also cleared after the result of an item marked last

module prime_factor_count_max_tracker #(
    parameter int VALUE_BITS = 31
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  [VALUE_BITS-1:0]               value,
    input  wire                                 last,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [pfcmt_pkg::TOTAL_W-1:0]       total_factors,
    output logic [pfcmt_pkg::DISTINCT_W-1:0]    distinct_factors,
    output logic [pfcmt_pkg::BEST_W-1:0]        best_total_value,
    output logic [pfcmt_pkg::TOTAL_W-1:0]       best_total_count,
    output logic [pfcmt_pkg::BEST_W-1:0]        best_distinct_value,
    output logic [pfcmt_pkg::DISTINCT_W-1:0]    best_distinct_count,
    output logic                                set_done
);
    import pfcmt_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int SQ_W  = VB + 2;           // room for the square one step past the root
    localparam int CNT_W = $clog2(VB + 1);   // factor counts at full precision
    localparam int BIT_W = $clog2(VB);       // quotient bit counter

    typedef enum logic [2:0] {
        IDLE,
        TEST,
        DIV,
        STEP,
        FINISH
    } state_t;

    state_t             state_reg;
    logic [VB-1:0]      val_reg;        // value of the item in work
    logic               last_reg;
    logic [VB-1:0]      rem_reg;        // remaining cofactor
    logic [VB-1:0]      d_reg;          // trial divisor
    logic [SQ_W-1:0]    sq_reg;         // divisor squared, kept by increments
    logic [VB-1:0]      quo_reg;        // dividend shifting out, quotient shifting in
    logic [VB-1:0]      part_reg;       // partial remainder
    logic [BIT_W-1:0]   bit_reg;
    logic [CNT_W-1:0]   t_reg;
    logic [CNT_W-1:0]   k_reg;
    logic               found_reg;      // current divisor already counted as distinct

    logic [VB-1:0]      top_total_value_reg;
    logic [CNT_W-1:0]   top_total_count_reg;
    logic [VB-1:0]      top_distinct_value_reg;
    logic [CNT_W-1:0]   top_distinct_count_reg;

    logic               out_valid_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [DISTINCT_W-1:0]  distinct_reg;
    logic [BEST_W-1:0]      btv_reg;
    logic [TOTAL_W-1:0]     btc_reg;
    logic [BEST_W-1:0]      bdv_reg;
    logic [DISTINCT_W-1:0]  bdc_reg;
    logic                   done_reg;

    // one restoring division step
    logic [VB:0]        shifted;
    logic               ge;
    logic [VB:0]        diff;
    logic [VB-1:0]      part_next;
    logic [VB-1:0]      quo_next;

    // best update
    logic [VB-1:0]      ntv_next;
    logic [CNT_W-1:0]   ntc_next;
    logic [VB-1:0]      ndv_next;
    logic [CNT_W-1:0]   ndc_next;

    logic               in_xfer;
    logic               out_free;

    always_comb
    begin
        shifted   = {part_reg, quo_reg[VB-1]};
        ge        = shifted >= {1'b0, d_reg};
        diff      = shifted - {1'b0, d_reg};
        part_next = ge ? diff[VB-1:0] : shifted[VB-1:0];
        quo_next  = {quo_reg[VB-2:0], ge};
    end

    always_comb
    begin
        if (t_reg > top_total_count_reg)
        begin
            ntc_next = t_reg;
            ntv_next = val_reg;
        end
        else
        begin
            ntc_next = top_total_count_reg;
            ntv_next = top_total_value_reg;
        end
        if (k_reg > top_distinct_count_reg)
        begin
            ndc_next = k_reg;
            ndv_next = val_reg;
        end
        else
        begin
            ndc_next = top_distinct_count_reg;
            ndv_next = top_distinct_value_reg;
        end
    end

    assign in_stall = (state_reg != IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= IDLE;
            val_reg                <= '0;
            last_reg               <= 1'b0;
            rem_reg                <= '0;
            d_reg                  <= VB'(FIRST_DIVISOR);
            sq_reg                 <= '0;
            quo_reg                <= '0;
            part_reg               <= '0;
            bit_reg                <= '0;
            t_reg                  <= '0;
            k_reg                  <= '0;
            found_reg              <= 1'b0;
            top_total_value_reg    <= '0;
            top_total_count_reg    <= '0;
            top_distinct_value_reg <= '0;
            top_distinct_count_reg <= '0;
            out_valid_reg          <= 1'b0;
            total_reg              <= '0;
            distinct_reg           <= '0;
            btv_reg                <= '0;
            btc_reg                <= '0;
            bdv_reg                <= '0;
            bdc_reg                <= '0;
            done_reg               <= 1'b0;
        end
        else
        begin
            // result taken, and no new one loaded in the same cycle
            if (out_valid_reg && !out_stall && state_reg != FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_xfer)
                    begin
                        val_reg   <= value;
                        last_reg  <= last;
                        rem_reg   <= value;
                        d_reg     <= VB'(FIRST_DIVISOR);
                        sq_reg    <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
                        t_reg     <= '0;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        if (value < VB'(FIRST_DIVISOR))
                        begin
                            state_reg <= FINISH;
                        end
                        else
                        begin
                            state_reg <= TEST;
                        end
                    end
                end

                TEST:
                begin
                    if (sq_reg <= SQ_W'(rem_reg))
                    begin
                        quo_reg   <= rem_reg;
                        part_reg  <= '0;
                        bit_reg   <= '0;
                        state_reg <= DIV;
                    end
                    else
                    begin
                        // leftover cofactor above one is a prime of its own
                        if (rem_reg > VB'(1))
                        begin
                            t_reg <= t_reg + 1'b1;
                            k_reg <= k_reg + 1'b1;
                        end
                        state_reg <= FINISH;
                    end
                end

                DIV:
                begin
                    quo_reg  <= quo_next;
                    part_reg <= part_next;
                    bit_reg  <= bit_reg + 1'b1;
                    if (bit_reg == BIT_W'(VB - 1))
                    begin
                        state_reg <= STEP;
                    end
                end

                STEP:
                begin
                    if (part_reg == '0)
                    begin
                        // divides: keep quotient and try the same divisor again
                        rem_reg   <= quo_reg;
                        t_reg     <= t_reg + 1'b1;
                        if (!found_reg)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                        found_reg <= 1'b1;
                        part_reg  <= '0;
                        bit_reg   <= '0;
                        state_reg <= DIV;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_reg     <= d_reg + 1'b1;
                        sq_reg    <= sq_reg + SQ_W'({d_reg, 1'b1});
                        found_reg <= 1'b0;
                        state_reg <= TEST;
                    end
                end

                FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        total_reg     <= TOTAL_W'(t_reg);
                        distinct_reg  <= DISTINCT_W'(k_reg);
                        btv_reg       <= BEST_W'(ntv_next);
                        btc_reg       <= TOTAL_W'(ntc_next);
                        bdv_reg       <= BEST_W'(ndv_next);
                        bdc_reg       <= DISTINCT_W'(ndc_next);
                        done_reg      <= last_reg;
                        if (last_reg)
                        begin
                            top_total_value_reg    <= '0;
                            top_total_count_reg    <= '0;
                            top_distinct_value_reg <= '0;
                            top_distinct_count_reg <= '0;
                        end
                        else
                        begin
                            top_total_value_reg    <= ntv_next;
                            top_total_count_reg    <= ntc_next;
                            top_distinct_value_reg <= ndv_next;
                            top_distinct_count_reg <= ndc_next;
                        end
                        state_reg <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid           = out_valid_reg;
    assign total_factors       = total_reg;
    assign distinct_factors    = distinct_reg;
    assign best_total_value    = btv_reg;
    assign best_total_count    = btc_reg;
    assign best_distinct_value = bdv_reg;
    assign best_distinct_count = bdc_reg;
    assign set_done            = done_reg;

    // checks

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input accepted but block not busy");

    a_best_total_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (top_total_count_reg == '0) == (top_total_value_reg == '0))
        else $error("best total value and count disagree");

    a_best_distinct_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (top_distinct_count_reg == '0) == (top_distinct_value_reg == '0))
        else $error("best distinct value and count disagree");

    a_partial_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV || state_reg == STEP) |-> (part_reg < d_reg))
        else $error("partial remainder not below divisor");

    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV) |-> (d_reg >= VB'(FIRST_DIVISOR)))
        else $error("trial divisor below two");

endmodule

`default_nettype wire
